// ===== sv/hid_pkg.sv =====
// Shared types and constants for the heartbeat interval detector.
`default_nettype none

package hid_pkg;

    // Ring of legal intervals that are averaged; a power of two
    localparam int AVG_DEPTH = 4;
    localparam int RING_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int RUN_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W = 16 + RING_IDX_W;

    // Register reset values
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd300;
    localparam logic [15:0] MAX_INTERVAL_RST = 16'd2000;
    localparam logic [3:0] CONFIRM_COUNT_RST = 4'd5;

    // Register indexes
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [1:0] REG_CONFIRM_COUNT = 2'd2;

    localparam logic [3:0] FALL_COUNT_MAX = 4'd15;
    localparam logic [15:0] ERROR_COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] min_interval_ms;
        logic [15:0] max_interval_ms;
        logic [3:0] confirm_count;
    } hid_cfg_t;

    typedef struct packed {
        logic beat_valid;
        logic [15:0] avg_interval_ms;
        logic [31:0] phase_delay_ms;
        logic [15:0] early_peak_errors;
    } hid_result_t;

endpackage

`default_nettype wire

// ===== sv/hid_cfg.sv =====
// Configuration register file of the heartbeat interval detector.
`default_nettype none

module hid_cfg
    import hid_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic wr_en,
    input wire logic [1:0] wr_index,
    input wire logic [15:0] wr_data,
    output hid_cfg_t cfg
);

    hid_cfg_t cfg_reg;
    hid_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_MIN_INTERVAL: cfg_next.min_interval_ms = wr_data;
                REG_MAX_INTERVAL: cfg_next.max_interval_ms = wr_data;
                REG_CONFIRM_COUNT: cfg_next.confirm_count = wr_data[3:0];
                default: cfg_next = cfg_reg;   // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval_ms <= MIN_INTERVAL_RST;
            cfg_reg.max_interval_ms <= MAX_INTERVAL_RST;
            cfg_reg.confirm_count <= CONFIRM_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/hid_core.sv =====
// Peak tracking, beat confirmation, interval ring and averaging state.
`default_nettype none

module hid_core
    import hid_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic go,
    input wire logic signed [15:0] sample,
    input wire logic [31:0] time_ms,
    input wire hid_cfg_t cfg,
    output hid_result_t result
);

    logic seen_first_reg, seen_first_next;
    logic signed [15:0] prev_sample_reg, prev_sample_next;
    logic [31:0] prev_time_reg, prev_time_next;
    logic [31:0] peak_time_reg, peak_time_next;
    logic [31:0] last_beat_reg, last_beat_next;
    logic [3:0] fall_count_reg, fall_count_next;
    logic [RUN_W-1:0] legal_run_reg, legal_run_next;
    logic [RING_IDX_W-1:0] ring_idx_reg, ring_idx_next;
    logic [15:0] ring_reg [AVG_DEPTH];
    logic [15:0] avg_reg, avg_next;
    logic [15:0] err_reg, err_next;

    logic fall;
    logic confirm;
    logic legal;
    logic ring_wr;
    logic fire;
    logic [3:0] fall_inc;
    logic [31:0] peak_eff;
    logic [31:0] interval;
    logic [RUN_W-1:0] run_inc;
    logic [SUM_W-1:0] sum;
    logic [15:0] avg_new;

    always_comb
    begin
        fall = seen_first_reg && (sample < prev_sample_reg);
        fall_inc = fall_count_reg + 4'd1;
        // first fall of a run marks the previous sample as the peak
        peak_eff = (fall && (fall_count_reg == 4'd0)) ? prev_time_reg : peak_time_reg;
        confirm = fall && (fall_count_reg != FALL_COUNT_MAX) && (fall_inc == cfg.confirm_count);
        interval = peak_eff - last_beat_reg;
        legal = (interval >= {16'd0, cfg.min_interval_ms})
            && (interval <= {16'd0, cfg.max_interval_ms});
        run_inc = (legal_run_reg == RUN_W'(AVG_DEPTH)) ? legal_run_reg
            : legal_run_reg + RUN_W'(1);
        ring_wr = confirm && legal;
        fire = ring_wr && (run_inc == RUN_W'(AVG_DEPTH));

        sum = '0;
        for (int i = 0; i < AVG_DEPTH; i++)
        begin
            if (ring_idx_reg == RING_IDX_W'(i))
                sum = sum + SUM_W'(interval[15:0]);
            else
                sum = sum + SUM_W'(ring_reg[i]);
        end
        avg_new = 16'(sum / AVG_DEPTH);

        seen_first_next = 1'b1;
        prev_sample_next = sample;
        prev_time_next = time_ms;
        peak_time_next = peak_eff;
        last_beat_next = confirm ? peak_eff : last_beat_reg;
        fall_count_next = fall_count_reg;
        err_next = err_reg;
        if (fall)
        begin
            if (fall_count_reg != FALL_COUNT_MAX)
                fall_count_next = fall_inc;
        end
        else if (seen_first_reg)
        begin
            // run ended before it ran past the confirm count
            if ((fall_count_reg <= cfg.confirm_count) && (err_reg != ERROR_COUNT_MAX))
                err_next = err_reg + 16'd1;
            fall_count_next = 4'd0;
        end

        legal_run_next = legal_run_reg;
        if (confirm)
            legal_run_next = legal ? run_inc : '0;
        ring_idx_next = ring_idx_reg;
        if (ring_wr)
            ring_idx_next = (ring_idx_reg == RING_IDX_W'(AVG_DEPTH - 1)) ? '0
                : ring_idx_reg + RING_IDX_W'(1);
        avg_next = fire ? avg_new : avg_reg;

        result.beat_valid = fire;
        result.avg_interval_ms = avg_next;
        result.phase_delay_ms = fire ? (time_ms - peak_eff) : 32'd0;
        result.early_peak_errors = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg <= 1'b0;
            prev_sample_reg <= '0;
            prev_time_reg <= '0;
            peak_time_reg <= '0;
            last_beat_reg <= '0;
            fall_count_reg <= '0;
            legal_run_reg <= '0;
            ring_idx_reg <= '0;
            avg_reg <= '0;
            err_reg <= '0;
            for (int i = 0; i < AVG_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else if (go)
        begin
            seen_first_reg <= seen_first_next;
            prev_sample_reg <= prev_sample_next;
            prev_time_reg <= prev_time_next;
            peak_time_reg <= peak_time_next;
            last_beat_reg <= last_beat_next;
            fall_count_reg <= fall_count_next;
            legal_run_reg <= legal_run_next;
            ring_idx_reg <= ring_idx_next;
            avg_reg <= avg_next;
            err_reg <= err_next;
            if (ring_wr)
                ring_reg[ring_idx_reg] <= interval[15:0];
        end
    end

    // an average only comes out once the run is full
    assert property (@(posedge clk) disable iff (!rst_n)
        go && result.beat_valid |=> legal_run_reg == RUN_W'(AVG_DEPTH))
        else $error("beat reported without a full legal run");

    // error counter never goes backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> err_reg >= $past(err_reg))
        else $error("early peak error count decreased");

    // phase delay only travels with a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        go && !result.beat_valid |-> result.phase_delay_ms == 32'd0)
        else $error("phase delay computed without a beat");

endmodule

`default_nettype wire

// ===== sv/heartbeat_interval_detector.sv =====
// Top level of the heartbeat interval detector: channels, input and result registers.
//
// Usage:
//   s_* channel: one word per sensor sample. tdata[15:0] = sample (signed Q8.8),
//     tdata[47:16] = time_ms. The first sample after reset is only stored.
//   m_* channel: exactly one word per sample. tuser = beat_valid, tdata[15:0] =
//     averaged beat interval, tdata[47:16] = phase delay since the beat (zero
//     unless beat_valid), tdata[63:48] = saturating early-peak error count.
//   cfg_* channel: register writes, always ready. Index 0 = min interval,
//     1 = max interval, 2 = confirm count; index 3 is dropped. Write only while
//     no sample is in flight.
// Path: an accepted sample waits in the input register until the result register is
//   free or draining; its result word is then registered and shown on m_*.
// Throughput: one sample per cycle while m_* is not held; the whole update is a
//   single pass between the input register and the result register.
// Stall: a held result keeps its word; one more sample waits in the input
//   register, then s_tready drops until m_tready returns.
// Reset: rst_n clears the control and core state (not the payload registers),
//   registers return to 300 / 2000 / 5, no words are pending.
`default_nettype none

module heartbeat_interval_detector
    import hid_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    output logic s_tready,
    input wire logic [47:0] s_tdata,      // [15:0] sample, [47:16] time_ms
    output logic m_tvalid,
    input wire logic m_tready,
    output logic [63:0] m_tdata,          // [15:0] avg_interval_ms,
                                          // [47:16] phase_delay_ms,
                                          // [63:48] early_peak_errors
    output logic m_tuser,                 // [0] beat_valid
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [1:0] cfg_index,
    input wire logic [15:0] cfg_data
);

    hid_cfg_t cfg;
    hid_result_t result;

    logic in_valid_reg;
    logic signed [15:0] in_sample_reg;
    logic [31:0] in_time_reg;
    logic out_valid_reg;
    hid_result_t out_reg;
    logic go;

    assign cfg_ready = 1'b1;

    hid_cfg u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data(cfg_data),
        .cfg(cfg)
    );

    // process the held sample when the result register is free or draining
    assign go = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;

    hid_core u_core (
        .clk(clk),
        .rst_n(rst_n),
        .go(go),
        .sample(in_sample_reg),
        .time_ms(in_time_reg),
        .cfg(cfg),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (go)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= s_tdata[15:0];
            in_time_reg <= s_tdata[47:16];
        end
        if (go)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.beat_valid;
    assign m_tdata = {out_reg.early_peak_errors, out_reg.phase_delay_ms,
        out_reg.avg_interval_ms};

    // a processed sample always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        go |=> out_valid_reg)
        else $error("processed sample lost its result slot");

    // a waiting sample is kept until processed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !go |=> in_valid_reg && $stable(in_time_reg))
        else $error("waiting sample dropped or changed");

    // phase delay is only reported with a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[47:16] == 32'd0)
        else $error("phase delay without a beat");

endmodule

`default_nettype wire

// ===== tb/heartbeat_interval_detector_tb.sv =====
// Self-checking testbench for the heartbeat interval detector: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module heartbeat_interval_detector_tb;
    import hid_pkg::*;

    // Index 3 is decoded by nobody; writes to it must leave every register alone
    localparam logic [1:0] REG_SPARE = 2'd3;
    // Random samples per configuration phase
    localparam int PHASE_ITEMS = 210;
    // Cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 5000;
    // Quiet cycles after the last result
    localparam int TAIL_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;       // [15:0] sample, [47:16] time_ms
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [63:0] m_tdata;            // [15:0] avg_interval_ms, [47:16] phase_delay_ms,
                                     // [63:48] early_peak_errors
    logic m_tuser;                   // [0] beat_valid
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    heartbeat_interval_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and of the detector
    // ------------------------------------------------------------------
    logic [15:0] win_lo = MIN_INTERVAL_RST;     // shortest legal interval
    logic [15:0] win_hi = MAX_INTERVAL_RST;     // longest legal interval
    logic [3:0] need_drops = CONFIRM_COUNT_RST; // falls that confirm a peak

    logic have_prev = 1'b0;
    logic signed [15:0] last_level = '0;
    logic [31:0] last_stamp = '0;
    logic [31:0] crest_time = '0;               // tentative peak
    logic [31:0] beat_stamp = '0;               // time of the last confirmed beat
    logic [3:0] drop_run = '0;                  // falls in a row, sticks at 15
    int good_run = 0;                           // legal beats in a row, sticks at depth
    int slot = 0;
    logic [15:0] spans [AVG_DEPTH];
    logic [15:0] mean_span = '0;
    logic [15:0] early_errs = '0;

    // Stimulus and scoreboard
    logic [47:0] pending_samples [$];           // words waiting for the driver
    hid_result_t awaited_reports [$];           // predicted result words, oldest first
    hid_result_t want;
    int outstanding = 0;                        // queued samples whose result has not come
    int samples_queued = 0;
    int samples_sent = 0;
    int reports_seen = 0;
    int beats_seen = 0;
    int settings_done = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // Generator state for synthetic heartbeat waveforms
    int gen_level = 0;
    logic [31:0] gen_time = '0;

    initial
    begin
        for (int i = 0; i < AVG_DEPTH; i++)
            spans[i] = '0;
    end

    // Advances the detector copy by one sample and returns the result word it must produce.
    function automatic hid_result_t track_heartbeat(input logic signed [15:0] s,
                                                    input logic [31:0] t);
        hid_result_t r;
        logic fresh;
        logic [31:0] span;
        int total;
        fresh = 1'b0;
        if (!have_prev)
        begin
            have_prev = 1'b1;
        end
        else if (s < last_level)
        begin
            // Only the increment that reaches a count acts; a stuck counter does nothing
            if (drop_run != FALL_COUNT_MAX)
            begin
                drop_run = drop_run + 4'd1;
                if (drop_run == 4'd1)
                    crest_time = last_stamp;
                if (drop_run == need_drops)
                begin
                    span = crest_time - beat_stamp;
                    beat_stamp = crest_time;
                    if (span < {16'd0, win_lo} || span > {16'd0, win_hi})
                    begin
                        // ring and average survive an illegal interval
                        good_run = 0;
                    end
                    else
                    begin
                        if (good_run < AVG_DEPTH)
                            good_run++;
                        spans[slot] = span[15:0];
                        slot = (slot + 1) % AVG_DEPTH;
                        if (good_run >= AVG_DEPTH)
                        begin
                            total = 0;
                            for (int i = 0; i < AVG_DEPTH; i++)
                                total += spans[i];
                            mean_span = 16'(total / AVG_DEPTH);
                            fresh = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin
            // equal counts as not falling; a short run ended early
            if (drop_run <= need_drops && early_errs != ERROR_COUNT_MAX)
                early_errs = early_errs + 16'd1;
            drop_run = '0;
        end
        last_level = s;
        last_stamp = t;
        r.beat_valid = fresh;
        r.avg_interval_ms = mean_span;
        r.phase_delay_ms = fresh ? (t - beat_stamp) : 32'd0;
        r.early_peak_errors = early_errs;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds s_* from the pending queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_reports.push_back(track_heartbeat(s_tdata[15:0], s_tdata[47:16]));
                samples_sent++;
            end
            // A word is held until taken; only then may the slot be refilled or emptied
            if (!s_tvalid || s_tready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tdata <= pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure on m_*, compares every result word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_tvalid && m_tready)
            begin
                reports_seen++;
                outstanding--;
                if (m_tuser)
                    beats_seen++;
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected: tdata %h tuser %b",
                                 $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (m_tuser !== want.beat_valid
                        || m_tdata[15:0] !== want.avg_interval_ms
                        || m_tdata[47:16] !== want.phase_delay_ms
                        || m_tdata[63:48] !== want.early_peak_errors)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch: expected beat %0b interval %0d phase %0d errors %0d",
                                     $time, want.beat_valid, want.avg_interval_ms,
                                     want.phase_delay_ms, want.early_peak_errors);
                            $display("%0t:           got beat %0b interval %0d phase %0d errors %0d",
                                     $time, m_tuser, m_tdata[15:0], m_tdata[47:16],
                                     m_tdata[63:48]);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
                     quiet_cycles, outstanding);
            $display("heartbeat_interval_detector_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers, all called from the sequencing initial block
    // ------------------------------------------------------------------
    task automatic add_sample(input int level, input logic [31:0] stamp);
        if (level > 32767)
            level = 32767;
        else if (level < -32768)
            level = -32768;
        pending_samples.push_back({stamp, 16'(level)});
        outstanding++;
        samples_queued++;
    endtask

    // One heartbeat: n_fall falling samples off the last crest, then n_rise rising
    // samples up to a new crest. The samples span exactly 'span' ms, so the next
    // confirmed beat sees that interval if nothing breaks the pattern.
    task automatic add_cycle(input int span, input int n_fall, input int n_rise);
        int n;
        int dt;
        int crest;
        int need;
        int left;
        n = n_fall + n_rise;
        dt = span / n;
        crest = int'($urandom_range(30000)) - 10000;
        for (int k = 0; k < n; k++)
        begin
            gen_time = gen_time + 32'(dt) + ((k == n - 1) ? 32'(span % n) : 32'd0);
            if (k < n_fall)
            begin
                gen_level = gen_level - int'($urandom_range(800, 1));
                if (gen_level < -32768)
                    gen_level = -32768;
            end
            else
            begin
                need = crest - gen_level;
                left = n - k;
                if (need >= left)
                    gen_level = gen_level + need / left;
                else
                    gen_level = gen_level + int'($urandom_range(50, 1));
            end
            add_sample(gen_level, gen_time);
        end
    endtask

    // Junk samples that break up the pattern; times may jump anywhere
    task automatic add_noise(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(1))
                gen_time = $urandom;
            else
                gen_time = gen_time + $urandom_range(300);
            gen_level = int'($signed(16'($urandom)));
            add_sample(gen_level, gen_time);
        end
    endtask

    // Waits until every queued sample has come back as a result word
    task automatic drain();
        while (outstanding > 0)
            @(posedge clk);
    endtask

    // Holds cfg_valid high across back-to-back writes; the caller lowers it
    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MIN_INTERVAL: win_lo = val;
            REG_MAX_INTERVAL: win_hi = val;
            REG_CONFIRM_COUNT: need_drops = val[3:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [3:0] cc, input bit spare,
                             input int src_idle, input int stall);
        int first;
        int r;
        int span;
        int n_fall;
        int cc_now;
        drain();
        put_reg(REG_MIN_INTERVAL, lo);
        put_reg(REG_MAX_INTERVAL, hi);
        // upper data bits are junk; only the low nibble is the count
        put_reg(REG_CONFIRM_COUNT, {12'($urandom), cc});
        if (spare)
            put_reg(REG_SPARE, 16'($urandom));
        cfg_valid <= 1'b0;
        settings_done++;
        src_idle_pct = src_idle;
        sink_stall_pct = stall;
        gen_time = $urandom;
        gen_level = 0;
        cc_now = int'(need_drops);
        first = samples_queued;
        while (samples_queued - first < PHASE_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                add_noise($urandom_range(4, 1));
            end
            else
            begin
                // mostly intervals inside the window, some anywhere
                if (r < 28)
                    span = $urandom_range(70000);
                else
                    span = $urandom_range(int'(win_lo), int'(win_hi));
                r = $urandom_range(99);
                if (r < 12)
                    n_fall = $urandom_range(18, 15);        // runs into the 15 ceiling
                else if (r < 25)
                    n_fall = (cc_now > 1) ? $urandom_range(cc_now - 1, 1) : 1;
                else
                    n_fall = cc_now + $urandom_range(2);
                if (n_fall < 1)
                    n_fall = 1;
                add_cycle(span, n_fall, $urandom_range(6, 1));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing: reset, directed samples, then randomized phases
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, under the reset register values (300 / 2000 / 5)
        add_sample(0, 32'd0);                   // first sample, only stored
        add_sample(32767, 32'd1000);            // rise ends an empty run: early error
        add_sample(32767, 32'd1100);            // equal is not a fall
        add_sample(1000, 32'd1200);             // first fall, peak at 1100
        add_sample(500, 32'd1300);
        add_sample(0, 32'd1400);
        add_sample(-1, 32'd1500);
        add_sample(-32768, 32'd1600);           // fifth fall: first beat, interval = peak time
        add_sample(-32768, 32'd1700);           // run of exactly the count still errors
        add_sample(-32767, 32'd1650);           // time runs backwards
        add_sample(-32768, 32'hFFFF_FFFF);      // fall at the top of the time range
        add_sample(32767, 32'd5);               // time wraps; short run ends
        add_sample(100, 32'd10);
        add_sample(90, 32'd20);
        add_sample(80, 32'd30);
        add_sample(70, 32'd40);
        add_sample(60, 32'd50);                 // confirm with a wrapped, illegal interval
        add_sample(50, 32'd60);                 // one fall past the count
        add_sample(60, 32'd70);                 // long run ends without an error

        // Register settings include the extremes, an inverted window and counts 0 / 15
        run_phase(16'd300, 16'd2000, 4'd5, 1'b0, 0, 0);
        run_phase(16'd0, 16'd65535, 4'd1, 1'b1, 57, 0);
        run_phase(16'd400, 16'd1200, 4'd14, 1'b0, 0, 57);
        run_phase(16'd1500, 16'd500, 4'd3, 1'b0, 25, 25);
        run_phase(16'd800, 16'd800, 4'd2, 1'b1, 0, 0);
        run_phase(16'd65535, 16'd65535, 4'd15, 1'b0, 57, 0);
        run_phase(16'd0, 16'd0, 4'd0, 1'b0, 0, 57);
        run_phase(16'd200, 16'd3000, 4'd4, 1'b1, 25, 25);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d samples over %0d register settings, stream idling up to 57 in 100",
                 samples_sent, settings_done);
        $display("run: %0d result words checked, %0d averaged beats, %0d mismatches",
                 reports_seen, beats_seen, mismatches);
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("heartbeat_interval_detector_tb: done, clean");
        else
            $display("heartbeat_interval_detector_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hid_pkg.sv
sv/hid_cfg.sv
sv/hid_core.sv
sv/heartbeat_interval_detector.sv
tb/heartbeat_interval_detector_tb.sv
